[design/tpef_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch pen event filter package
// Shared widths, event codes, register indexes, reset defaults and the per-axis setup type.
// ----------------------------------------------------------------------------
package tpef_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAW_BITS   = 13;
  localparam int TOL_BITS   = 8;
  localparam int OFF_BITS   = 12;
  localparam int SIZE_BITS  = 13;
  localparam int KIND_BITS  = 2;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;

  localparam int IN_DATA_BITS  = ((2 * RAW_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  localparam int SUM_BITS = (RAW_BITS > COORD_BITS) ? RAW_BITS + 1 : COORD_BITS + 1;

  localparam logic [KIND_BITS-1:0] KIND_DOWN = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_DRAG = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_UP   = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE_X   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE_Y   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_X      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_Y      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd5;

  localparam logic [TOL_BITS-1:0]  TOLERANCE_RESET = 8'd4;
  localparam logic [OFF_BITS-1:0]  OFFSET_X_RESET  = 12'd8;
  localparam logic [OFF_BITS-1:0]  OFFSET_Y_RESET  = 12'd16;
  localparam logic [SIZE_BITS-1:0] WIDTH_RESET     = 13'd800;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET    = 13'd480;

  typedef struct packed {
    logic [TOL_BITS-1:0]         tolerance;
    logic signed [OFF_BITS-1:0]  offset;
    logic [SIZE_BITS-1:0]        size;
  } axis_cfg_t;

endpackage

[design/tpef_axis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch pen event filter axis unit
// Dead-band test against the last accepted reading, then offset and clamp.
// ----------------------------------------------------------------------------
module tpef_axis (
  input  logic signed [tpef_pkg::RAW_BITS-1:0]   raw,
  input  logic signed [tpef_pkg::RAW_BITS-1:0]   last_raw,
  input  tpef_pkg::axis_cfg_t                    cfg,
  input  logic                                   armed,
  output logic                                   take,
  output logic [tpef_pkg::COORD_BITS-1:0]        point
);

  localparam int DIFF_BITS = tpef_pkg::RAW_BITS + 1;
  localparam int SB        = tpef_pkg::SUM_BITS;
  localparam int CB        = tpef_pkg::COORD_BITS;
  localparam int ZB        = tpef_pkg::SIZE_BITS;

  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        mag;
  logic signed [SB-1:0]        sum;
  logic [ZB-1:0]               size_m1;
  logic                        size_big;
  logic [CB-1:0]               lim;
  logic signed [SB-1:0]        lim_s;

  always_comb begin
    diff = DIFF_BITS'(raw) - DIFF_BITS'(last_raw);
    mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    take = !armed || (mag > DIFF_BITS'(cfg.tolerance));
  end

  always_comb begin
    sum      = SB'(raw) + SB'(cfg.offset);
    size_m1  = (cfg.size == '0) ? '0 : cfg.size - ZB'(1);
    size_big = (CB < ZB) && ((size_m1 >> CB) != '0);
    lim      = size_big ? '1 : CB'(size_m1);
    lim_s    = SB'($signed({1'b0, lim}));
    if (sum[SB-1]) begin
      point = '0;
    end else if (sum > lim_s) begin
      point = lim;
    end else begin
      point = CB'(sum);
    end
  end

endmodule

[design/touch_pen_event_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch pen event filter
// Turns touch samples into pen-down, drag and pen-up events with calibrated,
// clamped screen coordinates.
// ----------------------------------------------------------------------------
// An accepted sample passes the input register, then the event register.
// Throughput is one sample per cycle unless the output stalls; the input and
// event registers let a new sample enter while a finished event waits.
// Reset is synchronous and clears the pen state and both registers' valid
// flags, and loads the default tolerances, offsets and screen size.
module touch_pen_event_filter (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [tpef_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [tpef_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [tpef_pkg::IN_DATA_BITS-1:0]       s_tdata,  // raw_x, raw_y, zero fill
  input  logic                                    s_tuser,  // touched
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [tpef_pkg::OUT_DATA_BITS-1:0]      m_tdata,  // point_x, point_y
  output logic [tpef_pkg::KIND_BITS-1:0]          m_tuser   // event_kind
);

  localparam int RB = tpef_pkg::RAW_BITS;
  localparam int CB = tpef_pkg::COORD_BITS;

  tpef_pkg::axis_cfg_t cfg_x;
  tpef_pkg::axis_cfg_t cfg_y;

  logic                 in_valid;
  logic signed [RB-1:0] in_raw_x;
  logic signed [RB-1:0] in_raw_y;
  logic                 in_touched;

  logic                 was_touched;
  logic signed [RB-1:0] last_raw_x;
  logic signed [RB-1:0] last_raw_y;
  logic [CB-1:0]        held_x;
  logic [CB-1:0]        held_y;

  logic                 out_free;
  logic                 advance;
  logic                 take_x;
  logic                 take_y;
  logic                 axis_x_take;
  logic                 axis_y_take;
  logic [CB-1:0]        place_x;
  logic [CB-1:0]        place_y;
  logic [CB-1:0]        held_x_next;
  logic [CB-1:0]        held_y_next;
  logic                 emit;
  logic [tpef_pkg::KIND_BITS-1:0] kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_x.tolerance <= tpef_pkg::TOLERANCE_RESET;
      cfg_y.tolerance <= tpef_pkg::TOLERANCE_RESET;
      cfg_x.offset    <= tpef_pkg::OFFSET_X_RESET;
      cfg_y.offset    <= tpef_pkg::OFFSET_Y_RESET;
      cfg_x.size      <= tpef_pkg::WIDTH_RESET;
      cfg_y.size      <= tpef_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpef_pkg::REG_TOLERANCE_X:   cfg_x.tolerance <= cfg_data[tpef_pkg::TOL_BITS-1:0];
        tpef_pkg::REG_TOLERANCE_Y:   cfg_y.tolerance <= cfg_data[tpef_pkg::TOL_BITS-1:0];
        tpef_pkg::REG_OFFSET_X:      cfg_x.offset    <= cfg_data[tpef_pkg::OFF_BITS-1:0];
        tpef_pkg::REG_OFFSET_Y:      cfg_y.offset    <= cfg_data[tpef_pkg::OFF_BITS-1:0];
        tpef_pkg::REG_SCREEN_WIDTH:  cfg_x.size      <= cfg_data[tpef_pkg::SIZE_BITS-1:0];
        tpef_pkg::REG_SCREEN_HEIGHT: cfg_y.size      <= cfg_data[tpef_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_raw_x   <= s_tdata[RB-1:0];
      in_raw_y   <= s_tdata[2*RB-1:RB];
      in_touched <= s_tuser;
    end
  end

  tpef_axis u_axis_x (
    .raw      (in_raw_x),
    .last_raw (last_raw_x),
    .cfg      (cfg_x),
    .armed    (was_touched),
    .take     (axis_x_take),
    .point    (place_x)
  );

  tpef_axis u_axis_y (
    .raw      (in_raw_y),
    .last_raw (last_raw_y),
    .cfg      (cfg_y),
    .armed    (was_touched),
    .take     (axis_y_take),
    .point    (place_y)
  );

  always_comb begin
    take_x      = in_touched && axis_x_take;
    take_y      = in_touched && axis_y_take;
    held_x_next = take_x ? place_x : held_x;
    held_y_next = take_y ? place_y : held_y;
    emit        = in_touched ? (take_x || take_y) : was_touched;
    if (!in_touched) begin
      kind = tpef_pkg::KIND_UP;
    end else if (was_touched) begin
      kind = tpef_pkg::KIND_DRAG;
    end else begin
      kind = tpef_pkg::KIND_DOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_touched <= 1'b0;
      last_raw_x  <= '0;
      last_raw_y  <= '0;
      held_x      <= '0;
      held_y      <= '0;
    end else if (advance) begin
      was_touched <= in_touched;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
      if (take_x) begin
        last_raw_x <= in_raw_x;
      end
      if (take_y) begin
        last_raw_y <= in_raw_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && emit) begin
      m_tdata <= tpef_pkg::OUT_DATA_BITS'({held_y_next, held_x_next});
      m_tuser <= kind;
    end
  end

endmodule

[design/tpef_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch pen event filter checker
// Port-level checks on event order, output hold, idle after reset and latency.
// ----------------------------------------------------------------------------
module tpef_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  input  logic                                    s_tready,
  input  logic                                    m_tvalid,
  input  logic                                    m_tready,
  input  logic [tpef_pkg::OUT_DATA_BITS-1:0]      m_tdata,
  input  logic [tpef_pkg::KIND_BITS-1:0]          m_tuser
);

  logic pen_is_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_is_up <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      pen_is_up <= (m_tuser == tpef_pkg::KIND_UP);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("event changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("event valid after reset");

  a_down_after_up: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && pen_is_up |-> m_tuser == tpef_pkg::KIND_DOWN)
    else $error("first event of a touch is not pen-down");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("event without a sample two cycles before");

endmodule

bind touch_pen_event_filter tpef_checker u_tpef_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
